### rtl/core/ycam_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ycam_pkg
// Shared types, constants and tables for the yaw/pitch camera view block.
// ----------------------------------------------------------------------------
package ycam_pkg;

    localparam int BASIS_FRAC_BITS_DEF = 14;
    localparam int POS_WIDTH_DEF       = 32;
    localparam int CORDIC_STEPS_DEF    = 16;

    localparam int ANGLE_W = 14;  // yaw, quarter degrees
    localparam int PITCH_W = 10;  // pitch, quarter degrees

    localparam logic [15:0] SPEED_RST = 16'd2048;

    localparam int ANGLE_Q30_PER_QDEG = 4685083;
    localparam int CORDIC_GAIN_Q30    = 652032874;
    localparam int YAW_TURN           = 1440;
    localparam int HALF_TURN          = 720;
    localparam int QUARTER_TURN       = 360;
    localparam int YAW_REWRAP         = 5760;
    localparam int PITCH_LIMIT        = 356;

    localparam logic SEL_YAW   = 1'b0;
    localparam logic SEL_PITCH = 1'b1;

    localparam logic [1:0] ROW_RIGHT = 2'd0;
    localparam logic [1:0] ROW_UP    = 2'd1;
    localparam logic [1:0] ROW_DIR   = 2'd2;

    typedef enum logic [2:0] {
        REQ_LOOK  = 3'd0,
        REQ_FWD   = 3'd1,
        REQ_BACK  = 3'd2,
        REQ_LEFT  = 3'd3,
        REQ_RIGHT = 3'd4,
        REQ_UP    = 3'd5,
        REQ_DOWN  = 3'd6
    } t_req;

    typedef enum logic [3:0] {
        MOP_NONE = 4'd0,
        MOP_LIN  = 4'd1,
        MOP_SD   = 4'd2,
        MOP_CPCY = 4'd3,
        MOP_CPSY = 4'd4,
        MOP_SPCY = 4'd5,
        MOP_SPSY = 4'd6,
        MOP_MV   = 4'd7,
        MOP_HI   = 4'd8,
        MOP_LO   = 4'd9,
        MOP_FIN  = 4'd10
    } t_mop;

    typedef struct packed {
        logic [2:0]        req_type;
        logic signed [11:0] mouse_dx;
        logic signed [11:0] mouse_dy;
        logic [15:0]       time_step;
    } t_in;

    typedef struct packed {
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic signed [31:0] trans_x;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_z;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       clr_first;
        logic       ang_upd;
        logic       cord_start;
        logic       cord_sel;
        logic       cord_cap;
        t_mop       mop;
        logic [1:0] row;
        logic [1:0] col;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic       first_pending;
        logic [2:0] req;
        logic       cord_done;
    } t_sts;

    // arctan(2^-i) in Q30
    function automatic logic [29:0] f_atan(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388438;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/yaw_pitch_camera_view_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yaw_pitch_camera_view_update
// First-person camera: turns by mouse counts, moves along its basis and
// returns the view matrix (basis rows plus translation) for every request.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (i_in_valid/o_in_ready, i_in_data): one look, move or
//    no-op request at a time; taken only while the sequencer is idle.
//  - Result channel (o_out_valid/i_out_ready, o_out_data): one view matrix per
//    request, held in an output register.
//  - i_cfg_we/i_cfg_wdata write move_speed (Q8.8); write only while idle.
//  - Steps from accept to result valid, for the first look and unused codes:
//    dispatch, 21 dot-product ops of the shared 33x33 multiplier, drain,
//    emit; moves add 6 setup ops first. A later look adds the angle step,
//    two serial CORDIC passes and the setup ops before the dot products.
//  - The next request is taken the cycle after the result is loaded, even
//    while that result waits in the output register; none is taken while
//    a request is still in flight.
//  - A stalled receiver holds the last result; a new result waits in the
//    final state until the output register frees up.
//  - Synchronous reset restores yaw/pitch 0, origin position, identity basis,
//    move_speed 2048 and re-arms the ignored first look.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_view_update import ycam_pkg::*; #(
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_BITS_DEF,
    parameter int POS_WIDTH       = POS_WIDTH_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // sequencer: handshakes and the per-request op program
    ycam_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath: camera state, CORDIC, multiplier, result register
    ycam_dp #(
        .BASIS_FRAC_BITS (BASIS_FRAC_BITS),
        .POS_WIDTH       (POS_WIDTH),
        .CORDIC_STEPS    (CORDIC_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in        (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_out       (o_out_data)
    );

endmodule
`default_nettype wire

### rtl/core/ycam_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ycam_cordic
// Iterative rotation-mode CORDIC: sine and cosine (Q30) of an angle in
// quarter degrees, one rotation per cycle.
// ----------------------------------------------------------------------------
module ycam_cordic import ycam_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [ANGLE_W-1:0] i_angle,
    output logic                           o_done,
    output logic signed [31:0]             o_sin,
    output logic signed [31:0]             o_cos
);

    localparam int XW = 34;
    localparam int IW = $clog2(CORDIC_STEPS);

    localparam logic signed [15:0] L_TURN = 16'(YAW_TURN);
    localparam logic signed [15:0] L_HALF = 16'(HALF_TURN);
    localparam logic signed [15:0] L_QTR  = 16'(QUARTER_TURN);
    localparam logic signed [XW-1:0] K_Q30 = XW'(ANGLE_Q30_PER_QDEG);
    localparam logic signed [XW-1:0] GAIN  = XW'(CORDIC_GAIN_Q30);

    typedef enum logic [1:0] {C_IDLE, C_LOAD, C_ITER} t_cst;

    t_cst                r_state;
    logic signed [9:0]   r_r;
    logic                r_neg;
    logic signed [XW-1:0] r_x, r_y, r_z;
    logic [IW-1:0]       r_i;

    logic signed [15:0]  red;
    logic signed [15:0]  q;
    logic                neg;
    logic signed [XW-1:0] at, n_x, n_y, n_z;

    // fold angle into [-360, 360] with a sign flip for the outer half
    always_comb begin
        red = 16'(i_angle);
        for (int k = 0; k < 6; k++) begin
            if (red >= L_HALF) begin
                red = red - L_TURN;
            end else if (red < -L_HALF) begin
                red = red + L_TURN;
            end
        end
        neg = 1'b0;
        q   = red;
        if (red > L_QTR) begin
            q   = red - L_HALF;
            neg = 1'b1;
        end else if (red < -L_QTR) begin
            q   = red + L_HALF;
            neg = 1'b1;
        end
    end

    always_comb begin
        at = $signed(XW'(f_atan(5'(r_i))));
        if (r_z >= 0) begin
            n_x = r_x - (r_y >>> r_i);
            n_y = r_y + (r_x >>> r_i);
            n_z = r_z - at;
        end else begin
            n_x = r_x + (r_y >>> r_i);
            n_y = r_y - (r_x >>> r_i);
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_r     <= q[9:0];
                        r_neg   <= neg;
                        r_state <= C_LOAD;
                    end
                end
                C_LOAD: begin
                    r_z     <= XW'(r_r) * K_Q30;
                    r_x     <= GAIN;
                    r_y     <= '0;
                    r_i     <= '0;
                    r_state <= C_ITER;
                end
                C_ITER: begin
                    r_x <= n_x;
                    r_y <= n_y;
                    r_z <= n_z;
                    if (r_i == IW'(CORDIC_STEPS - 1)) begin
                        o_sin   <= r_neg ? 32'(-n_y) : 32'(n_y);
                        o_cos   <= r_neg ? 32'(-n_x) : 32'(n_x);
                        o_done  <= 1'b1;
                        r_state <= C_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/core/ycam_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ycam_dp
// Camera datapath: angles, position, basis, one shared multiplier with a
// tagged result register, dot-product accumulators and the result register.
// ----------------------------------------------------------------------------
module ycam_dp import ycam_pkg::*; #(
    parameter int BASIS_FRAC_BITS = BASIS_FRAC_BITS_DEF,
    parameter int POS_WIDTH       = POS_WIDTH_DEF,
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire t_in         i_in,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    output t_out             o_out
);

    localparam int F    = BASIS_FRAC_BITS;
    localparam int BW   = F + 2;
    localparam int PW   = POS_WIDTH;
    localparam int PH   = PW - 16;
    localparam int MW   = 33;
    localparam int PRW  = 2 * MW;
    localparam int HI_W = BW + PH + 2;
    localparam int LO_W = BW + 18;
    localparam int CW   = (HI_W > F + 19) ? HI_W : F + 19;
    localparam int TW   = F + 37;

    localparam logic signed [BW-1:0]  ONE     = BW'(1) << F;
    localparam logic signed [PRW-1:0] RB_HALF = PRW'(1) << (59 - F);
    localparam logic signed [PRW-1:0] MV_HALF = PRW'(1) << (F + 15);
    localparam logic signed [CW-1:0]  LIM     = CW'(1) << (F + 17);
    localparam logic signed [CW-1:0]  NLIM    = -LIM;
    localparam logic signed [TW-1:0]  T_HALF  = TW'(1) << (F - 1);
    localparam logic signed [TW-1:0]  T_MAX   = TW'(32'sh7fff_ffff);
    localparam logic signed [TW-1:0]  T_MIN   = TW'(32'sh8000_0000);
    localparam logic signed [PW+1:0]  PMAX    = {3'b000, {(PW-1){1'b1}}};
    localparam logic signed [PW+1:0]  PMIN    = {3'b111, {(PW-1){1'b0}}};

    localparam logic signed [15:0] L_TURN  = 16'(YAW_TURN);
    localparam logic signed [15:0] L_REWR  = 16'(YAW_REWRAP);
    localparam logic signed [15:0] L_PLIM  = 16'(PITCH_LIMIT);
    localparam logic signed [15:0] L_YMAX  = 16'sd8191;
    localparam logic signed [15:0] L_YMIN  = -16'sd8192;

    // state
    logic [15:0]               r_speed;
    logic signed [ANGLE_W-1:0] r_yaw;
    logic signed [PITCH_W-1:0] r_pitch;
    logic                      r_first;
    logic signed [PW-1:0]      r_pos [3];
    logic signed [BW-1:0]      r_vec [3][3];   // [row][component]

    // item and work registers
    logic [2:0]                r_req;
    logic signed [11:0]        r_dx, r_dy;
    logic [15:0]               r_dt;
    logic signed [31:0]        r_sy, r_cy, r_sp, r_cp;
    logic [31:0]               r_sd;
    logic signed [PRW-1:0]     r_prod;
    t_mop                      r_tag_mop;
    logic [1:0]                r_tag_row, r_tag_col;
    logic signed [HI_W-1:0]    r_hi;
    logic signed [LO_W-1:0]    r_lo;
    logic signed [31:0]        r_trans [3];

    logic                      cord_done;
    logic signed [31:0]        cord_sin, cord_cos;

    function automatic logic signed [BW-1:0] f_rq30(input logic signed [31:0] v,
                                                    input logic ng);
        logic signed [33:0] t;
        t = ng ? -34'(v) : 34'(v);
        t = t + (34'sd1 <<< (29 - F));
        return BW'(t >>> (30 - F));
    endfunction

    function automatic logic signed [15:0] f_o16(input logic signed [BW-1:0] v);
        logic signed [BW+15:0] e;
        e = (BW+16)'(v);
        return e[15:0];
    endfunction

    ycam_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.cord_start),
        .i_angle ((i_cmd.cord_sel == SEL_PITCH) ? ANGLE_W'(r_pitch) : r_yaw),
        .o_done  (cord_done),
        .o_sin   (cord_sin),
        .o_cos   (cord_cos)
    );

    assign o_sts.first_pending = r_first;
    assign o_sts.req           = r_req;
    assign o_sts.cord_done     = cord_done;

    // ---------------- angle update
    logic signed [15:0] dx3, dy3, y0, y1, y2, p0, p1;
    always_comb begin
        dx3 = (16'(r_dx) <<< 1) + 16'(r_dx);
        dy3 = (16'(r_dy) <<< 1) + 16'(r_dy);
        y0  = 16'(r_yaw) + dx3;
        if (y0 > L_TURN) begin
            y1 = y0 - L_TURN;
        end else if (y0 < -L_TURN) begin
            y1 = y0 + L_TURN;
        end else begin
            y1 = y0;
        end
        if (y1 > L_YMAX) begin
            y2 = y1 - L_REWR;
        end else if (y1 < L_YMIN) begin
            y2 = y1 + L_REWR;
        end else begin
            y2 = y1;
        end
        p0 = 16'(r_pitch) - dy3;
        if (p0 > L_PLIM) begin
            p1 = L_PLIM;
        end else if (p0 < -L_PLIM) begin
            p1 = -L_PLIM;
        end else begin
            p1 = p0;
        end
    end

    // ---------------- move direction from the request
    logic [1:0] mv_row;
    logic       mv_add;
    always_comb begin
        case (r_req)
            REQ_FWD:   begin mv_row = ROW_DIR;   mv_add = 1'b0; end
            REQ_BACK:  begin mv_row = ROW_DIR;   mv_add = 1'b1; end
            REQ_LEFT:  begin mv_row = ROW_RIGHT; mv_add = 1'b0; end
            REQ_RIGHT: begin mv_row = ROW_RIGHT; mv_add = 1'b1; end
            REQ_UP:    begin mv_row = ROW_UP;    mv_add = 1'b1; end
            REQ_DOWN:  begin mv_row = ROW_UP;    mv_add = 1'b0; end
            default:   begin mv_row = ROW_RIGHT; mv_add = 1'b1; end
        endcase
    end

    // ---------------- multiplier operand select
    logic [1:0]            rd_row;
    logic signed [BW-1:0]  vsel;
    logic signed [PW-1:0]  psel;
    logic signed [MW-1:0]  ma, mb;
    always_comb begin
        rd_row = (i_cmd.mop == MOP_MV) ? mv_row : i_cmd.row;
        vsel   = r_vec[rd_row][i_cmd.col];
        psel   = r_pos[i_cmd.col];
        case (i_cmd.mop)
            MOP_SD:   begin ma = MW'(r_speed);  mb = MW'(r_dt); end
            MOP_CPCY: begin ma = MW'(r_cp);     mb = MW'(r_cy); end
            MOP_CPSY: begin ma = MW'(r_cp);     mb = MW'(r_sy); end
            MOP_SPCY: begin ma = MW'(r_sp);     mb = MW'(r_cy); end
            MOP_SPSY: begin ma = MW'(r_sp);     mb = MW'(r_sy); end
            MOP_MV:   begin ma = MW'(vsel);     mb = $signed(MW'(r_sd)); end
            MOP_HI:   begin ma = MW'(vsel);     mb = MW'($signed(psel[PW-1:16])); end
            MOP_LO:   begin ma = MW'(vsel);     mb = $signed(MW'(psel[15:0])); end
            default:  begin ma = '0;            mb = '0; end
        endcase
    end

    // ---------------- consumers of the tagged product
    logic signed [PRW-1:0] rb_full, mv_full;
    logic signed [BW-1:0]  rb;
    logic signed [PW+1:0]  mv_d, mv_p, mv_sat;
    logic signed [HI_W-1:0] hi_n;
    logic signed [LO_W-1:0] lo_n;
    always_comb begin
        rb_full = ((-r_prod) + RB_HALF) >>> (60 - F);
        rb      = BW'(rb_full);
        mv_full = (r_prod + MV_HALF) >>> (F + 16);
        mv_d    = (PW+2)'(mv_full);
        mv_p    = mv_add ? (PW+2)'(r_pos[r_tag_col]) + mv_d
                         : (PW+2)'(r_pos[r_tag_col]) - mv_d;
        if (mv_p > PMAX) begin
            mv_sat = PMAX;
        end else if (mv_p < PMIN) begin
            mv_sat = PMIN;
        end else begin
            mv_sat = mv_p;
        end
        hi_n = (r_tag_col == 2'd0) ? HI_W'(r_prod) : r_hi + HI_W'(r_prod);
        lo_n = (r_tag_col == 2'd0) ? LO_W'(r_prod) : r_lo + LO_W'(r_prod);
    end

    // negated dot product, rounded and saturated
    logic signed [CW-1:0] hi_c;
    logic signed [TW-1:0] tot, tsh;
    logic signed [31:0]   fin;
    always_comb begin
        hi_c = CW'(r_hi);
        tot  = (TW'(r_hi) <<< 16) + TW'(r_lo);
        tsh  = (T_HALF - tot) >>> F;
        if (hi_c > LIM) begin
            fin = 32'sh8000_0000;
        end else if (hi_c < NLIM) begin
            fin = 32'sh7fff_ffff;
        end else if (tsh > T_MAX) begin
            fin = 32'sh7fff_ffff;
        end else if (tsh < T_MIN) begin
            fin = 32'sh8000_0000;
        end else begin
            fin = tsh[31:0];
        end
    end

    // ---------------- camera state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= SPEED_RST;
            r_yaw     <= '0;
            r_pitch   <= '0;
            r_first   <= 1'b1;
            r_tag_mop <= MOP_NONE;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                for (int j = 0; j < 3; j++) begin
                    r_vec[k][j] <= (k == j) ? ONE : '0;
                end
            end
        end else begin
            r_tag_mop <= i_cmd.mop;
            if (i_cfg_we) begin
                r_speed <= i_cfg_wdata;
            end
            if (i_cmd.clr_first) begin
                r_first <= 1'b0;
            end
            if (i_cmd.ang_upd) begin
                r_yaw   <= y2[ANGLE_W-1:0];
                r_pitch <= p1[PITCH_W-1:0];
            end
            case (r_tag_mop)
                MOP_LIN: begin
                    r_vec[ROW_RIGHT][0] <= f_rq30(r_sy, 1'b1);
                    r_vec[ROW_RIGHT][1] <= '0;
                    r_vec[ROW_RIGHT][2] <= f_rq30(r_cy, 1'b0);
                    r_vec[ROW_UP][1]    <= f_rq30(r_cp, 1'b0);
                    r_vec[ROW_DIR][1]   <= f_rq30(r_sp, 1'b1);
                end
                MOP_CPCY: r_vec[ROW_DIR][0] <= rb;
                MOP_CPSY: r_vec[ROW_DIR][2] <= rb;
                MOP_SPCY: r_vec[ROW_UP][0]  <= rb;
                MOP_SPSY: r_vec[ROW_UP][2]  <= rb;
                MOP_MV:   r_pos[r_tag_col]  <= mv_sat[PW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in.req_type;
            r_dx  <= i_in.mouse_dx;
            r_dy  <= i_in.mouse_dy;
            r_dt  <= i_in.time_step;
        end
        if (i_cmd.cord_cap) begin
            if (i_cmd.cord_sel == SEL_PITCH) begin
                r_sp <= cord_sin;
                r_cp <= cord_cos;
            end else begin
                r_sy <= cord_sin;
                r_cy <= cord_cos;
            end
        end
        r_prod    <= ma * mb;
        r_tag_row <= i_cmd.row;
        r_tag_col <= i_cmd.col;
        case (r_tag_mop)
            MOP_SD:  r_sd <= r_prod[31:0];
            MOP_HI:  r_hi <= hi_n;
            MOP_LO:  r_lo <= lo_n;
            MOP_FIN: r_trans[r_tag_row] <= fin;
            default: ;
        endcase
        if (i_cmd.emit) begin
            o_out.right_x <= f_o16(r_vec[ROW_RIGHT][0]);
            o_out.right_y <= f_o16(r_vec[ROW_RIGHT][1]);
            o_out.right_z <= f_o16(r_vec[ROW_RIGHT][2]);
            o_out.up_x    <= f_o16(r_vec[ROW_UP][0]);
            o_out.up_y    <= f_o16(r_vec[ROW_UP][1]);
            o_out.up_z    <= f_o16(r_vec[ROW_UP][2]);
            o_out.dir_x   <= f_o16(r_vec[ROW_DIR][0]);
            o_out.dir_y   <= f_o16(r_vec[ROW_DIR][1]);
            o_out.dir_z   <= f_o16(r_vec[ROW_DIR][2]);
            o_out.trans_x <= r_trans[ROW_RIGHT];
            o_out.trans_y <= r_trans[ROW_UP];
            o_out.trans_z <= r_trans[ROW_DIR];
        end
    end

endmodule
`default_nettype wire

### rtl/core/ycam_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ycam_ctrl
// Sequencer: dispatches a request, runs the angle/CORDIC steps, issues the
// multiplier program and hands the result to the output register.
// ----------------------------------------------------------------------------
module ycam_ctrl import ycam_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_ANG, S_CY_GO, S_CY_WAIT, S_CP_GO, S_CP_WAIT,
        S_PRE, S_DOT, S_DRAIN, S_EMIT
    } t_state;

    t_state     r_state;
    logic [2:0] r_cnt;
    logic [2:0] r_sub;
    logic [1:0] r_row;
    logic       r_look;
    logic       r_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE:    o_cmd.load = i_in_valid;
            S_DISP:    o_cmd.clr_first = (i_sts.req == REQ_LOOK) && i_sts.first_pending;
            S_ANG:     o_cmd.ang_upd = 1'b1;
            S_CY_GO:   begin o_cmd.cord_start = 1'b1; o_cmd.cord_sel = SEL_YAW; end
            S_CY_WAIT: begin o_cmd.cord_cap = i_sts.cord_done; o_cmd.cord_sel = SEL_YAW; end
            S_CP_GO:   begin o_cmd.cord_start = 1'b1; o_cmd.cord_sel = SEL_PITCH; end
            S_CP_WAIT: begin o_cmd.cord_cap = i_sts.cord_done; o_cmd.cord_sel = SEL_PITCH; end
            S_PRE: begin
                if (r_look) begin
                    case (r_cnt)
                        3'd0:    o_cmd.mop = MOP_LIN;
                        3'd1:    o_cmd.mop = MOP_CPCY;
                        3'd2:    o_cmd.mop = MOP_CPSY;
                        3'd3:    o_cmd.mop = MOP_SPCY;
                        3'd4:    o_cmd.mop = MOP_SPSY;
                        default: o_cmd.mop = MOP_NONE;
                    endcase
                end else begin
                    case (r_cnt)
                        3'd0: o_cmd.mop = MOP_SD;
                        3'd2, 3'd3, 3'd4: begin
                            o_cmd.mop = MOP_MV;
                            o_cmd.col = 2'(r_cnt - 3'd2);
                        end
                        default: o_cmd.mop = MOP_NONE;
                    endcase
                end
            end
            S_DOT: begin
                o_cmd.row = r_row;
                if (r_sub == 3'd6) begin
                    o_cmd.mop = MOP_FIN;
                end else begin
                    o_cmd.mop = r_sub[0] ? MOP_LO : MOP_HI;
                    o_cmd.col = r_sub[2:1];
                end
            end
            S_DRAIN:   ;
            S_EMIT:    o_cmd.emit = !r_ovalid || i_out_ready;
            default:   ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_sub    <= '0;
            r_row    <= '0;
            r_look   <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_DISP;
                    end
                end
                S_DISP: begin
                    r_cnt <= '0;
                    r_sub <= '0;
                    r_row <= ROW_RIGHT;
                    case (i_sts.req) inside
                        REQ_LOOK: begin
                            r_look  <= 1'b1;
                            r_state <= i_sts.first_pending ? S_DOT : S_ANG;
                        end
                        REQ_FWD, REQ_BACK, REQ_LEFT, REQ_RIGHT, REQ_UP, REQ_DOWN: begin
                            r_look  <= 1'b0;
                            r_state <= S_PRE;
                        end
                        default: r_state <= S_DOT;
                    endcase
                end
                S_ANG:   r_state <= S_CY_GO;
                S_CY_GO: r_state <= S_CY_WAIT;
                S_CY_WAIT: begin
                    if (i_sts.cord_done) begin
                        r_state <= S_CP_GO;
                    end
                end
                S_CP_GO: r_state <= S_CP_WAIT;
                S_CP_WAIT: begin
                    if (i_sts.cord_done) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (r_cnt == 3'd5) begin
                        r_state <= S_DOT;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_DOT: begin
                    if (r_sub == 3'd6) begin
                        r_sub <= '0;
                        if (r_row == ROW_DIR) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_row <= r_row + 2'd1;
                        end
                    end else begin
                        r_sub <= r_sub + 3'd1;
                    end
                end
                S_DRAIN: r_state <= S_EMIT;
                S_EMIT: begin
                    if (o_cmd.emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### bench/yaw_pitch_camera_view_update_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// yaw_pitch_camera_view_update_tb
// Drives look, move and no-op requests into the camera block, keeps its own camera
// model and compares every returned view matrix field by field.
// ----------------------------------------------------------------------------
module yaw_pitch_camera_view_update_tb import ycam_pkg::*;;

    // ------------------------------------------------------------------------
    // Camera model: angles, position, basis and move speed, all at block widths
    // ------------------------------------------------------------------------
    class cam_view_scoreboard;
        int            speed;
        int            yaw_q;
        int            pitch_q;
        longint        pos[3];
        longint        dir_v[3];
        longint        right_v[3];
        longint        up_v[3];
        bit            first_pending;
        t_out          view_q[$];
        int            errors;
        int            checked;

        function void reset_state();
            speed = SPEED_RST;
            yaw_q = 0;
            pitch_q = 0;
            for (int k = 0; k < 3; k++) begin
                pos[k] = 0;
                dir_v[k] = 0;
                right_v[k] = 0;
                up_v[k] = 0;
            end
            dir_v[2] = 64'sd1 <<< BASIS_FRAC_BITS_DEF;
            right_v[0] = 64'sd1 <<< BASIS_FRAC_BITS_DEF;
            up_v[1] = 64'sd1 <<< BASIS_FRAC_BITS_DEF;
            first_pending = 1;
        endfunction

        function longint round_shr(longint v, int s);
            return (v + (64'sd1 <<< (s - 1))) >>> s;
        endfunction

        // CORDIC rotation in Q30; returns sine and cosine
        function void sin_cos(int qd, output longint s, output longint c);
            int r;
            bit flip;
            longint x, y, z, nx;
            r = qd % YAW_TURN;
            flip = 0;
            x = CORDIC_GAIN_Q30;
            y = 0;
            if (r > HALF_TURN) r -= YAW_TURN;
            else if (r < -HALF_TURN) r += YAW_TURN;
            if (r > QUARTER_TURN) begin
                r -= HALF_TURN;
                flip = 1;
            end else if (r < -QUARTER_TURN) begin
                r += HALF_TURN;
                flip = 1;
            end
            z = longint'(r) * ANGLE_Q30_PER_QDEG;
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'(f_atan(i[4:0]));
                end else begin
                    nx = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'(f_atan(i[4:0]));
                end
                x = nx;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function void rebuild();
            longint sy, cy, sp, cp;
            int sh, sl;
            sh = 60 - BASIS_FRAC_BITS_DEF;
            sl = 30 - BASIS_FRAC_BITS_DEF;
            sin_cos(yaw_q, sy, cy);
            sin_cos(pitch_q, sp, cp);
            dir_v[0] = round_shr(-(cp * cy), sh);
            dir_v[1] = round_shr(-sp, sl);
            dir_v[2] = round_shr(-(cp * sy), sh);
            right_v[0] = round_shr(-sy, sl);
            right_v[1] = 0;
            right_v[2] = round_shr(cy, sl);
            up_v[0] = round_shr(-(sp * cy), sh);
            up_v[1] = round_shr(cp, sl);
            up_v[2] = round_shr(-(sp * sy), sh);
        endfunction

        // negated row . position, split in high and low halves as the block does
        function logic [31:0] neg_dot(longint row[3]);
            longint hi, lo, lim, t;
            hi = 0;
            lo = 0;
            lim = 64'sd1 <<< (BASIS_FRAC_BITS_DEF + 17);
            for (int k = 0; k < 3; k++) begin
                hi += row[k] * (pos[k] >>> 16);
                lo += row[k] * longint'(pos[k] & 64'hFFFF);
            end
            if (hi > lim) return 32'h8000_0000;
            if (hi < -lim) return 32'h7FFF_FFFF;
            t = round_shr(-(hi * 65536 + lo), BASIS_FRAC_BITS_DEF);
            if (t > 64'sd2147483647) t = 64'sd2147483647;
            if (t < -64'sd2147483648) t = -64'sd2147483648;
            return t[31:0];
        endfunction

        function void shift_pos(longint v[3], bit plus, int dt);
            longint d, p;
            for (int k = 0; k < 3; k++) begin
                d = round_shr(v[k] * speed * dt, BASIS_FRAC_BITS_DEF + 16);
                p = pos[k] + (plus ? d : -d);
                if (p > 64'sd2147483647) p = 64'sd2147483647;
                if (p < -64'sd2147483648) p = -64'sd2147483648;
                pos[k] = p;
            end
        endfunction

        // accepted request: advance the model and queue the expected matrix
        function void note_request(t_in r);
            int y, p, dt;
            t_out e;
            dt = r.time_step;
            case (r.req_type)
                REQ_LOOK: begin
                    if (first_pending) begin
                        first_pending = 0;
                    end else begin
                        y = yaw_q + int'(r.mouse_dx) * 3;
                        p = pitch_q - int'(r.mouse_dy) * 3;
                        if (y > YAW_TURN) y -= YAW_TURN;
                        else if (y < -YAW_TURN) y += YAW_TURN;
                        if (y > 8191) y -= YAW_REWRAP;
                        else if (y < -8192) y += YAW_REWRAP;
                        if (p > PITCH_LIMIT) p = PITCH_LIMIT;
                        else if (p < -PITCH_LIMIT) p = -PITCH_LIMIT;
                        yaw_q = y;
                        pitch_q = p;
                        rebuild();
                    end
                end
                REQ_FWD:   shift_pos(dir_v, 0, dt);
                REQ_BACK:  shift_pos(dir_v, 1, dt);
                REQ_LEFT:  shift_pos(right_v, 0, dt);
                REQ_RIGHT: shift_pos(right_v, 1, dt);
                REQ_UP:    shift_pos(up_v, 1, dt);
                REQ_DOWN:  shift_pos(up_v, 0, dt);
                default: ;
            endcase
            e.right_x = right_v[0][15:0];
            e.right_y = right_v[1][15:0];
            e.right_z = right_v[2][15:0];
            e.up_x = up_v[0][15:0];
            e.up_y = up_v[1][15:0];
            e.up_z = up_v[2][15:0];
            e.dir_x = dir_v[0][15:0];
            e.dir_y = dir_v[1][15:0];
            e.dir_z = dir_v[2][15:0];
            e.trans_x = neg_dot(right_v);
            e.trans_y = neg_dot(up_v);
            e.trans_z = neg_dot(dir_v);
            view_q.push_back(e);
        endfunction

        function void cmp(string nm, longint e, longint a);
            if (e != a) begin
                errors++;
                if (errors < 40)
                    $display("%0t mismatch %s expected %0d actual %0d", $realtime, nm, e, a);
            end
        endfunction

        function void check_view(t_out a);
            t_out e;
            if (view_q.size() == 0) begin
                errors++;
                $display("%0t unexpected view matrix, expected none, actual %h", $realtime, a);
                return;
            end
            e = view_q.pop_front();
            checked++;
            cmp("right_x", e.right_x, a.right_x);
            cmp("right_y", e.right_y, a.right_y);
            cmp("right_z", e.right_z, a.right_z);
            cmp("up_x", e.up_x, a.up_x);
            cmp("up_y", e.up_y, a.up_y);
            cmp("up_z", e.up_z, a.up_z);
            cmp("dir_x", e.dir_x, a.dir_x);
            cmp("dir_y", e.dir_y, a.dir_y);
            cmp("dir_z", e.dir_z, a.dir_z);
            cmp("trans_x", e.trans_x, a.trans_x);
            cmp("trans_y", e.trans_y, a.trans_y);
            cmp("trans_z", e.trans_z, a.trans_z);
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int RANDOM_REQS    = 1630;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    cam_view_scoreboard sb;
    int  idle_cycles;
    bit  timed_out;
    bit  drive_done;
    int  look_cnt;
    int  move_cnt;

    yaw_pitch_camera_view_update DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Model updates and checks happen on the edge where the handshake completes
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_view(o_out_data);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Watchdog: nothing accepted for too long means the block is stuck
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("timeout with %0d views pending", sb.view_q.size());
            $display("yaw_pitch_camera_view_update_tb failed");
            $finish;
        end
    end

    // Receiver: random stall before each result, with stall-free stretches
    initial begin
        int w;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // Send one request, after a given gap; valid holds until accepted
    task automatic push_req(logic [2:0] rt, logic signed [11:0] dx,
                            logic signed [11:0] dy, logic [15:0] dt, int gap);
        t_in r;
        r.req_type = rt;
        r.mouse_dx = dx;
        r.mouse_dy = dy;
        r.time_step = dt;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= r;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (rt == REQ_LOOK) look_cnt++;
        else move_cnt++;
    endtask

    task automatic rand_gap_push(logic [2:0] rt, logic signed [11:0] dx,
                                 logic signed [11:0] dy, logic [15:0] dt);
        push_req(rt, dx, dy, dt,
                 ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    endtask

    // Wait until every result is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.view_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_speed(logic [15:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.speed = v;
    endtask

    initial begin
        logic [15:0] speeds[5];
        logic [2:0]  rt;
        logic signed [11:0] dx, dy;
        sb = new();
        sb.reset_state();
        sb.errors = 0;
        sb.checked = 0;
        idle_cycles = 0;
        timed_out = 0;
        look_cnt = 0;
        move_cnt = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: moves before any look, first look is ignored,
        // then extreme turns, pitch clamp, yaw wrap and every move kind
        push_req(REQ_FWD, 0, 0, 16'hFFFF, 0);
        push_req(REQ_RIGHT, 0, 0, 16'h8000, 3);
        push_req(REQ_LOOK, 12'sd2047, -12'sd2048, 0, 0);
        push_req(REQ_LOOK, 12'sd2047, 12'sd2047, 16'hFFFF, 0);
        push_req(REQ_LOOK, -12'sd2048, -12'sd2048, 0, 1);
        push_req(REQ_LOOK, 12'sd480, 0, 0, 0);
        push_req(REQ_LOOK, 12'sd480, 12'sd119, 0, 0);
        push_req(REQ_LOOK, -12'sd1, 12'sd1, 0, 0);
        push_req(3'd7, 12'sd5, 12'sd5, 16'h1234, 0);
        for (int k = 1; k <= 6; k++) push_req(k[2:0], 0, 0, 16'hFFFF, 0);
        push_req(REQ_LOOK, 12'sd60, -12'sd30, 0, 0);
        for (int k = 1; k <= 6; k++) push_req(k[2:0], -12'sd1, 12'sd2047, 16'h0001, 2);
        drain();

        // Random phases, each with its own move speed, extremes included
        speeds[0] = 16'hFFFF;
        speeds[1] = 16'h0000;
        speeds[2] = 16'h0100;
        speeds[3] = 16'($urandom_range(0, 65535));
        speeds[4] = SPEED_RST;
        for (int ph = 0; ph < 5; ph++) begin
            write_speed(speeds[ph]);
            for (int n = 0; n < RANDOM_REQS / 5; n++) begin
                rt = 3'($urandom_range(0, 7));
                if ($urandom_range(0, 2) == 0) rt = REQ_LOOK;
                if ($urandom_range(0, 1) == 0) begin
                    dx = 12'($urandom_range(0, 4095));
                    dy = 12'($urandom_range(0, 4095));
                end else begin
                    dx = 12'(int'($urandom_range(0, 80)) - 40);
                    dy = 12'(int'($urandom_range(0, 80)) - 40);
                end
                rand_gap_push(rt, dx, dy, 16'($urandom_range(0, 65535)));
                // hold off once mid-phase until the pipeline is empty
                if (n == 100) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (sb.view_q.size() != 0) @(posedge i_clk);
                end
            end
            drain();
        end

        $display("covered %0d looks and %0d moves or no-ops over 5 written speed settings",
                 look_cnt, move_cnt);
        $display("%0d view matrices checked, %0d field mismatches",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.view_q.size() == 0)
            $display("yaw_pitch_camera_view_update_tb passed");
        else
            $display("yaw_pitch_camera_view_update_tb failed");
        $finish;
    end
endmodule

### filelist.f
rtl/core/ycam_pkg.sv
rtl/core/ycam_cordic.sv
rtl/core/ycam_dp.sv
rtl/core/ycam_ctrl.sv
rtl/core/yaw_pitch_camera_view_update.sv
bench/yaw_pitch_camera_view_update_tb.sv
